// ===== rtl/core/smoothed_pid_offset_regulator_unit_assert.svh =====
// assertion macros for the smoothed pid offset regulator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SMOOTHED_PID_OFFSET_REGULATOR_UNIT_ASSERT_SVH
`define SMOOTHED_PID_OFFSET_REGULATOR_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SPOR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define SPOR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spor_pkg.sv =====
// shared constants, codes and types of the smoothed pid offset regulator
// no dependencies
package spor_pkg;

    // field widths
    localparam int SAMPLE_BITS = 13;
    localparam int THR_W       = 13;
    localparam int GAIN_W      = 16;
    localparam int DT_W        = 16;
    localparam int DRIVE_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 32;

    // internal widths
    localparam int ERR_W   = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int DERR_W  = ERR_W + 1;
    localparam int PTERM_W = DERR_W + 2;
    localparam int MUL_A_W = SUM_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    // divide by ten through a scaled reciprocal, exact for the sample range
    localparam int SMOOTH_DIV  = 10;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + SMOOTH_DIV - 1) / SMOOTH_DIV;

    // serial divider, one quotient bit per cycle
    localparam int DIV_STEPS = DERR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // register reset values
    localparam int THR_RST = 0;
    localparam int KD_RST  = 1;
    localparam int KI_RST  = 0;
    localparam int DT_RST  = 1;
    localparam int MAX_RST = 4095;
    localparam int MIN_RST = -4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD,
        CFG_GAIN_KD,
        CFG_GAIN_KI,
        CFG_TIME_STEP,
        CFG_DRIVE_MAX,
        CFG_DRIVE_MIN
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SMOOTH,
        ST_LEVEL,
        ST_ERROR,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_I,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SMOOTH,
        OP_LEVEL,
        OP_ERROR,
        OP_DIV,
        OP_MUL_P,
        OP_MUL_I,
        OP_SUM,
        OP_OUT
    } op_t;

endpackage

// ===== rtl/core/spor_meas_if.sv =====
// sample channel of the regulator
// depends on spor_pkg
interface spor_meas_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [spor_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/spor_ctl_if.sv =====
// result channel of the regulator: drive and smoothed level
// depends on spor_pkg
interface spor_ctl_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [spor_pkg::DRIVE_W-1:0]     drive;
    logic signed [spor_pkg::SAMPLE_BITS-1:0] level;

    modport source (output valid, output drive, output level, input ready);
    modport sink (input valid, input drive, input level, output ready);
endinterface

// ===== rtl/core/spor_cfg_if.sv =====
// register write channel of the regulator
// depends on spor_pkg
interface spor_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [spor_pkg::CFG_IDX_W-1:0]       index;
    logic [spor_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/spor_ctrl.sv =====
// sequencer of the regulator: steps one word through the datapath
// depends on spor_pkg
module spor_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output spor_pkg::op_t op
);
    import spor_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // state, step counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op             = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                op         = OP_DIFF;
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                op         = OP_SMOOTH;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                op         = OP_LEVEL;
                state_next = ST_ERROR;
            end
            ST_ERROR:
            begin
                op         = OP_ERROR;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                op       = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                op         = OP_MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                op         = OP_MUL_I;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                op         = OP_SUM;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hand over once the output slot is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/spor_dpath.sv =====
// datapath of the regulator: registers, smoothing, error sum,
// serial divider, shared multiplier and clamp; depends on spor_pkg
module spor_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spor_pkg::op_t                          op,
    input  logic signed [spor_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   cfg_we,
    input  logic [spor_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [spor_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic signed [spor_pkg::DRIVE_W-1:0]     drive,
    output logic signed [spor_pkg::SAMPLE_BITS-1:0] level
);
    import spor_pkg::*;

    // configuration
    logic signed [THR_W-1:0]       thr_reg;
    logic signed [GAIN_W-1:0]      kd_reg;
    logic signed [GAIN_W-1:0]      ki_reg;
    logic        [DT_W-1:0]        dt_reg;
    logic signed [DRIVE_W-1:0]     max_reg;
    logic signed [DRIVE_W-1:0]     min_reg;

    // loop state
    logic signed [SAMPLE_BITS-1:0] level_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [ERR_W-1:0]       last_err_reg;

    // working registers
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ERR_W-1:0]       err_reg;
    logic        [DT_W-1:0]        rem_reg;
    logic        [DERR_W-1:0]      dvd_reg;
    logic                          neg_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [DRIVE_W-1:0]     drive_out_reg;
    logic signed [SAMPLE_BITS-1:0] level_out_reg;

    logic        [DIFF_W-1:0]      diff_mag;
    logic        [DIFF_W-1:0]      q_mag;
    logic        [DIFF_W-1:0]      step;
    logic signed [DIFF_W:0]        step_s;
    logic signed [DIFF_W:0]        lvl_wide;
    logic signed [ERR_W-1:0]       err;
    logic signed [DERR_W-1:0]      derr;
    logic        [DERR_W-1:0]      derr_mag;
    logic        [DT_W-1:0]        dt_eff;
    logic        [DT_W:0]          trial;
    logic        [DT_W:0]          trial_sub;
    logic                          ge;
    logic signed [DERR_W:0]        quo_s;
    logic signed [PTERM_W-1:0]     pterm;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [ACC_W-1:0]       max_ext;
    logic signed [ACC_W-1:0]       min_ext;
    logic signed [DRIVE_W-1:0]     clamped;

    // register writes and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_W'(THR_RST);
            kd_reg       <= GAIN_W'(KD_RST);
            ki_reg       <= GAIN_W'(KI_RST);
            dt_reg       <= DT_W'(DT_RST);
            max_reg      <= DRIVE_W'(MAX_RST);
            min_reg      <= DRIVE_W'(MIN_RST);
            level_reg    <= '0;
            sum_reg      <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    CFG_GAIN_KD:   kd_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_KI:   ki_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_TIME_STEP: dt_reg  <= cfg_data[DT_W-1:0];
                    CFG_DRIVE_MAX: max_reg <= cfg_data[DRIVE_W-1:0];
                    CFG_DRIVE_MIN: min_reg <= cfg_data[DRIVE_W-1:0];
                    default: ;
                endcase
            end
            if (op == OP_LEVEL)
            begin
                level_reg <= lvl_wide[SAMPLE_BITS-1:0];
            end
            if (op == OP_ERROR)
            begin
                sum_reg      <= sum_reg + SUM_W'(err);
                last_err_reg <= err;
            end
        end
    end

    // magnitude of the sample step, scaled quotient by ten
    assign diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign q_mag    = prod_reg[RECIP_SHIFT +: DIFF_W];

    // smoothing step, at least one toward the sample when they differ
    always_comb
    begin
        if (q_mag == '0)
        begin
            step = (diff_reg != '0) ? DIFF_W'(1) : '0;
        end
        else
        begin
            step = q_mag;
        end
    end
    assign step_s   = {1'b0, step};
    assign lvl_wide = diff_reg[DIFF_W-1] ? ((DIFF_W+1)'(level_reg) - step_s)
                                         : ((DIFF_W+1)'(level_reg) + step_s);

    // error and its change since the last word
    assign err      = ERR_W'(level_reg) - ERR_W'(thr_reg);
    assign derr     = DERR_W'(err) - DERR_W'(last_err_reg);
    assign derr_mag = derr[DERR_W-1] ? DERR_W'(-derr) : DERR_W'(derr);

    // restoring division step on magnitudes
    assign dt_eff    = (dt_reg == '0) ? DT_W'(1) : dt_reg;
    assign trial     = {rem_reg, dvd_reg[DERR_W-1]};
    assign ge        = (trial >= {1'b0, dt_eff});
    assign trial_sub = trial - {1'b0, dt_eff};

    // proportional plus derivative factor, both scaled by kd
    assign quo_s = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign pterm = PTERM_W'(err_reg) + PTERM_W'(quo_s);

    // shared multiplier operand select
    always_comb
    begin
        case (op)
            OP_SMOOTH:
            begin
                mul_a = $signed({{(MUL_A_W-DIFF_W){1'b0}}, diff_mag});
                mul_b = MUL_B_W'(RECIP);
            end
            OP_MUL_P:
            begin
                mul_a = MUL_A_W'(pterm);
                mul_b = MUL_B_W'(kd_reg);
            end
            OP_MUL_I:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(ki_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // clamp to the drive limits, upper limit checked first
    assign max_ext = ACC_W'(max_reg);
    assign min_ext = ACC_W'(min_reg);
    always_comb
    begin
        if (acc_reg > max_ext)
        begin
            clamped = max_reg;
        end
        else if (acc_reg < min_ext)
        begin
            clamped = min_reg;
        end
        else
        begin
            clamped = acc_reg[DRIVE_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:   sample_reg <= sample;
            OP_DIFF:   diff_reg   <= DIFF_W'(sample_reg) - DIFF_W'(level_reg);
            OP_SMOOTH: prod_reg   <= prod;
            OP_ERROR:
            begin
                err_reg <= err;
                dvd_reg <= derr_mag;
                neg_reg <= derr[DERR_W-1];
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
                dvd_reg <= {dvd_reg[DERR_W-2:0], ge};
            end
            OP_MUL_P:  prod_reg <= prod;
            OP_MUL_I:
            begin
                acc_reg  <= ACC_W'(prod_reg);
                prod_reg <= prod;
            end
            OP_SUM:    acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_OUT:
            begin
                drive_out_reg <= clamped;
                level_out_reg <= level_reg;
            end
            default: ;
        endcase
    end

    assign drive = drive_out_reg;
    assign level = level_out_reg;

endmodule

// ===== rtl/core/smoothed_pid_offset_regulator_unit.sv =====
// top level of the smoothed pid offset regulator
// depends on spor_pkg, the channel interfaces, spor_ctrl and spor_dpath
//
//   channel  role    payload
//   meas     sink    sample
//   ctl      source  drive, level
//   cfg      sink    index, data
//
// a word steps through the states diff, smooth, level, error, div, mul_p, mul_i, sum
// and out from one acceptance to the next; the serial divider gives one quotient bit
// per cycle and the one multiplier is shared; out waits while a stalled result is held;
// a new sample is taken only in the idle state.
// the result sits in an output register, so the next sample is accepted
// while it waits; a stalled result holds back only the following handover.
// reset is asynchronous and clears the control state, configuration and loop state
// to their defaults, not the working or output registers; config writes are always accepted.
module smoothed_pid_offset_regulator_unit (
    input  logic       clk,
    input  logic       rst_n,
    spor_meas_if.sink  meas,
    spor_ctl_if.source ctl,
    spor_cfg_if.sink   cfg
);
    import spor_pkg::*;

    op_t op;

    assign cfg.ready = 1'b1;

    // sequencer
    spor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (meas.valid),
        .in_ready  (meas.ready),
        .out_valid (ctl.valid),
        .out_ready (ctl.ready),
        .op        (op)
    );

    // datapath
    spor_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .sample    (meas.sample),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .drive     (ctl.drive),
        .level     (ctl.level)
    );

endmodule

// ===== rtl/core/spor_checker.sv =====
// port-level checks of the regulator, bound to the top level
// depends on spor_pkg and the assertion macro header
`include "smoothed_pid_offset_regulator_unit_assert.svh"

module spor_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [spor_pkg::DRIVE_W-1:0]     drive,
    input logic signed [spor_pkg::SAMPLE_BITS-1:0] level,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready
);
    // one word at a time: busy right after taking a sample
    `SPOR_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after accept")

    // no result can appear right after a sample is taken
    `SPOR_ASSERT_NXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "early result")

    // a stalled result holds its word
    `SPOR_ASSERT_NXT(a_result_holds, out_valid && !out_ready,
        out_valid && $stable(drive) && $stable(level), "stalled result changed")

    // register writes are never back-pressured
    `SPOR_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind smoothed_pid_offset_regulator_unit spor_checker u_spor_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (ctl.valid),
    .out_ready (ctl.ready),
    .drive     (ctl.drive),
    .level     (ctl.level),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

// ===== dv/tb_smoothed_pid_offset_regulator_unit.sv =====
// self-checking testbench of smoothed_pid_offset_regulator_unit: samples in, drive and level out
// depends on spor_pkg, the channel interfaces and the regulator rtl
// a local predictor tracks level, error sum and last error and checks every result word
module tb_smoothed_pid_offset_regulator_unit;
    import spor_pkg::*;

    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     RAND_PHASES   = 8;
    localparam int     PHASE_WORDS   = 53;
    localparam longint SMOOTH_RATIO  = 10;
    localparam int     SAMPLE_MAX    = 4095;
    localparam int     SAMPLE_MIN    = -4096;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // corner samples for the directed part
    localparam int EDGE_SAMPLES [14] = '{4095, -4096, 0, 5, 1, -1, 10, -10, 2730, -2731,
                                         4095, 100, 100, -4096};
    localparam int CORNER_SAMPLES [6] = '{4095, -4096, -1, 0, 4095, 2048};

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_RUNS
    } ready_mode_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]     drive;
        logic signed [SAMPLE_BITS-1:0] level;
    } reg_word_t;

    logic clk = 1'b0;
    logic rst_n;

    spor_meas_if meas_ch();
    spor_ctl_if  ctl_ch();
    spor_cfg_if  cfg_ch();

    smoothed_pid_offset_regulator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas_ch),
        .ctl   (ctl_ch),
        .cfg   (cfg_ch)
    );

    // predictor registers and state
    longint      thr_reg;
    longint      kd_reg;
    longint      ki_reg;
    logic [15:0] dt_reg;
    longint      dmax_reg;
    longint      dmin_reg;
    longint      level_state;
    logic [31:0] err_sum;
    longint      prev_err;

    // queues and counters
    logic signed [SAMPLE_BITS-1:0] sample_q[$];
    reg_word_t                     word_exp_q[$];
    reg_word_t                     want_word;
    int fail_count    = 0;
    int words_checked = 0;
    int samples_sent  = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int mode_cycles   = 0;
    int stall_run     = 0;
    ready_mode_t stall_mode;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one regulator step: smoothing, error sum, pid terms, clamp
    function automatic reg_word_t regulate_step(input logic signed [SAMPLE_BITS-1:0] smp);
        longint    s;
        longint    old_lvl;
        longint    lvl;
        longint    err;
        longint    sum;
        longint    dt;
        longint    drv;
        reg_word_t r;
        s = longint'(smp);
        old_lvl = level_state;
        lvl = old_lvl + (s - old_lvl) / SMOOTH_RATIO;
        // stuck level gets nudged by one toward the sample
        if (lvl == old_lvl && s != lvl)
            lvl = (s > lvl) ? lvl + 1 : lvl - 1;
        level_state = lvl;
        err = lvl - thr_reg;
        err_sum = err_sum + err[31:0];
        sum = longint'($signed(err_sum));
        dt = longint'(dt_reg);
        if (dt == 0)
            dt = 1;
        drv = err * kd_reg + sum * ki_reg + ((err - prev_err) / dt) * kd_reg;
        if (drv > dmax_reg)
            drv = dmax_reg;
        else if (drv < dmin_reg)
            drv = dmin_reg;
        prev_err = err;
        r.drive = drv[DRIVE_W-1:0];
        r.level = lvl[SAMPLE_BITS-1:0];
        return r;
    endfunction

    // mirror of a register write
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_THRESHOLD: thr_reg  = longint'($signed(value[THR_W-1:0]));
            CFG_GAIN_KD:   kd_reg   = longint'($signed(value));
            CFG_GAIN_KI:   ki_reg   = longint'($signed(value));
            CFG_TIME_STEP: dt_reg   = value;
            CFG_DRIVE_MAX: dmax_reg = longint'($signed(value));
            CFG_DRIVE_MIN: dmin_reg = longint'($signed(value));
            default: ;
        endcase
    endfunction

    // register write through the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(idx, value);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // hold until every sample is sent and every result word is back,
    // looked at on the falling edge once the rising edge updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || meas_ch.valid || word_exp_q.size() != 0);
    endtask

    // sample driver: bursts with random gaps, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_ch.valid  <= 1'b0;
            meas_ch.sample <= '0;
        end
        else
        begin
            if (meas_ch.valid && meas_ch.ready)
            begin
                word_exp_q.push_back(regulate_step(meas_ch.sample));
                samples_sent++;
            end
            if (!meas_ch.valid || meas_ch.ready)
            begin
                if (gap_left > 0 || sample_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    meas_ch.valid <= 1'b0;
                end
                else
                begin
                    meas_ch.valid  <= 1'b1;
                    meas_ch.sample <= sample_q.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // result receiver: stall pattern changes to a random mode after a random stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_ch.ready <= 1'b0;
            stall_mode = READY_ALWAYS;
            mode_cycles = 0;
            stall_run = 0;
        end
        else
        begin
            if (mode_cycles == 0)
            begin
                stall_mode = ready_mode_t'($urandom_range(0, 2));
                mode_cycles = $urandom_range(50, 300);
            end
            mode_cycles--;
            case (stall_mode)
                READY_ALWAYS: ctl_ch.ready <= 1'b1;
                READY_RANDOM: ctl_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_run == 0)
                    begin
                        ctl_ch.ready <= ~ctl_ch.ready;
                        stall_run = $urandom_range(1, 40);
                    end
                    else
                        stall_run--;
                end
            endcase
        end
    end

    // result monitor: compare each word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && ctl_ch.valid && ctl_ch.ready)
        begin
            if (word_exp_q.size() == 0)
            begin
                $error("result word with no sample pending: drive %0d level %0d",
                       ctl_ch.drive, ctl_ch.level);
                fail_count++;
            end
            else
            begin
                want_word = word_exp_q.pop_front();
                words_checked++;
                if (ctl_ch.drive !== want_word.drive)
                begin
                    $error("drive mismatch: expected %0d, actual %0d", want_word.drive,
                           ctl_ch.drive);
                    fail_count++;
                end
                if (ctl_ch.level !== want_word.level)
                begin
                    $error("level mismatch: expected %0d, actual %0d", want_word.level,
                           ctl_ch.level);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     word_exp_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int          v;
        int          target;
        int          lo;
        int          hi;
        logic [15:0] w;
        meas_ch.valid  = 1'b0;
        meas_ch.sample = '0;
        ctl_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        rst_n          = 1'b0;
        thr_reg     = longint'(THR_RST);
        kd_reg      = longint'(KD_RST);
        ki_reg      = longint'(KI_RST);
        dt_reg      = 16'(DT_RST);
        dmax_reg    = longint'(MAX_RST);
        dmin_reg    = longint'(MIN_RST);
        level_state = 0;
        err_sum     = '0;
        prev_err    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes, nudge, truncation both ways
        foreach (EDGE_SAMPLES[i])
            sample_q.push_back(SAMPLE_BITS'(EDGE_SAMPLES[i]));
        wait_idle();

        // top gains, zero time step, full limits, spare indexes ignored
        write_reg(CFG_THRESHOLD, 16'hEFFF);
        write_reg(CFG_GAIN_KD, 16'h7FFF);
        write_reg(CFG_GAIN_KI, 16'h8000);
        write_reg(CFG_TIME_STEP, 16'h0000);
        write_reg(CFG_DRIVE_MAX, 16'h7FFF);
        write_reg(CFG_DRIVE_MIN, 16'h8000);
        write_reg(IDX_SPARE_LO, 16'h5A5A);
        write_reg(IDX_SPARE_HI, 16'hFFFF);
        foreach (CORNER_SAMPLES[i])
            sample_q.push_back(SAMPLE_BITS'(CORNER_SAMPLES[i]));
        wait_idle();

        // opposite extremes, slowest time step, crossed limits
        write_reg(CFG_THRESHOLD, 16'h1000);
        write_reg(CFG_GAIN_KD, 16'h8000);
        write_reg(CFG_GAIN_KI, 16'h7FFF);
        write_reg(CFG_TIME_STEP, 16'hFFFF);
        write_reg(CFG_DRIVE_MAX, 16'hFF9C);
        write_reg(CFG_DRIVE_MIN, 16'h0064);
        foreach (CORNER_SAMPLES[i])
            sample_q.push_back(SAMPLE_BITS'(CORNER_SAMPLES[i]));
        wait_idle();

        // random phases, each with fresh register settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // threshold: extremes or any pattern, upper bits ignored
            case ($urandom_range(0, 3))
                0:       w = 16'hF000;
                1:       w = 16'h0FFF;
                default: w = 16'($urandom);
            endcase
            write_reg(CFG_THRESHOLD, w);
            // kd mostly small so the output is not always pinned
            case ($urandom_range(0, 4))
                0:       w = 16'h7FFF;
                1:       w = 16'h8000;
                2:       w = 16'($urandom);
                default: w = 16'(int'($urandom_range(0, 64)) - 32);
            endcase
            write_reg(CFG_GAIN_KD, w);
            case ($urandom_range(0, 4))
                0:       w = 16'h7FFF;
                1:       w = 16'h8000;
                2:       w = 16'h0000;
                default: w = 16'(int'($urandom_range(0, 6)) - 3);
            endcase
            write_reg(CFG_GAIN_KI, w);
            case ($urandom_range(0, 4))
                0:       w = 16'h0000;
                1:       w = 16'hFFFF;
                2:       w = 16'($urandom);
                default: w = 16'($urandom_range(1, 8));
            endcase
            write_reg(CFG_TIME_STEP, w);
            // limits: full range, random ordered, or crossed
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 3))
                0:
                begin
                    lo = -32768;
                    hi = 32767;
                end
                1:
                begin
                    if (lo < hi)
                    begin
                        v = lo;
                        lo = hi;
                        hi = v;
                    end
                end
                default:
                begin
                    if (lo > hi)
                    begin
                        v = lo;
                        lo = hi;
                        hi = v;
                    end
                end
            endcase
            write_reg(CFG_DRIVE_MAX, 16'(hi));
            write_reg(CFG_DRIVE_MIN, 16'(lo));
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(6, 7)), 16'($urandom));

            // samples: near a drifting target, full range, or extremes
            target = int'($urandom_range(0, 8191)) - 4096;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                case ($urandom_range(0, 5))
                    0:       v = int'($signed(13'($urandom)));
                    1:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                    2:
                    begin
                        target = int'($urandom_range(0, 8191)) - 4096;
                        v = target;
                    end
                    default: v = target + int'($urandom_range(0, 30)) - 15;
                endcase
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                if (v < SAMPLE_MIN)
                    v = SAMPLE_MIN;
                sample_q.push_back(13'(v));
            end
            wait_idle();
        end

        // drain and report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (word_exp_q.size() != 0)
        begin
            $error("%0d result words never arrived", word_exp_q.size());
            fail_count++;
        end
        $display("%0d samples regulated, %0d result words checked, %0d register writes",
                 samples_sent, words_checked, reg_writes);
        $display("settings ranged over gain and limit extremes, zero time step, crossed limits");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
